FILE: sv/drt_pkg.sv
package drt_pkg;

    localparam int XY_W   = 50;
    localparam int Z_W    = 34;
    localparam int ATAN_N = 24;
    localparam int ATAN_W = 5;

    localparam logic signed [31:0] KINV_Q30 = 32'sd652032874;

    localparam logic CFG_REVERSE_MOUNTING     = 1'b0;
    localparam logic CFG_STOP_SPEED_THRESHOLD = 1'b1;

    localparam logic [31:0] ATAN_TURN32 [ATAN_N] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic signed [31:0] yaw_rate_raw;
        logic        [47:0] sample_stamp;
        logic signed [15:0] speed;
        logic               speed_valid;
        logic        [15:0] heading;
        logic               heading_valid;
        logic signed [23:0] offset_moving;
        logic               offset_moving_valid;
        logic signed [23:0] offset_stopped;
    } drt_sample_t;

    typedef struct packed {
        logic signed [31:0] yaw_rate_corrected;
        logic signed [15:0] speed_out;
        logic signed [15:0] velocity_east;
        logic signed [15:0] velocity_north;
        logic signed [47:0] position_east;
        logic signed [47:0] position_north;
        logic               position_valid;
    } drt_result_t;

endpackage

FILE: sv/drt_sample_if.sv
interface drt_sample_if;
    logic                  valid;
    logic                  ready;
    drt_pkg::drt_sample_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/drt_result_if.sv
interface drt_result_if;
    logic                  valid;
    logic                  ready;
    drt_pkg::drt_result_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/dead_reckoning_trajectory_unit.sv
// dead reckoning trajectory unit
// sample channel (valid/ready) takes one imu item: raw yaw rate, stamp, speed,
// heading, offsets and validity flags; result channel returns one item per
// sample: corrected yaw rate, speed, east/north velocity and position.
// configuration: cfg_we writes cfg_data into register cfg_index
// (0 reverse mounting, 1 stop speed threshold); write only while idle.
// order: before estimating starts, an accepted sample goes straight to done;
// else init (start vector), CORDIC_STEPS rotations and fin (velocity), then,
// if the position is integrated too, mul/acc for each half and pos per axis.
// one item is in work at a time; sample.ready is high only in the idle state.
// the time is set by the shared cordic stage (one rotation per cycle) and the
// one shared 16x32 multiplier, used for the start vector and for the four
// partial products of velocity times time step.
// a finished item sits in the result register; the next sample is accepted
// while it waits, and that item is held in its last state until result.ready.
// reset clears the start phase, previous stamp, velocities, positions and the
// configuration (threshold back to 3); no clearing pass is needed.
module dead_reckoning_trajectory_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [14:0]  cfg_data,
    drt_sample_if.sink   sample,
    drt_result_if.source result
);

    localparam int ITER_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);
    localparam logic signed [drt_pkg::XY_W-1:0] ROUND_HALF = drt_pkg::XY_W'(2**29);

    typedef enum logic [2:0] {
        S_IDLE, S_INIT, S_ROT, S_FIN, S_MUL, S_ACC, S_POS, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_WAIT, PH_ONE, PH_EST
    } phase_t;

    state_t                       state_reg;
    phase_t                       phase_reg;
    logic                         reverse_reg;
    logic [14:0]                  threshold_reg;
    logic [47:0]                  prev_stamp_reg;
    logic signed [15:0]           ve_reg;
    logic signed [15:0]           vn_reg;
    logic signed [47:0]           pos_e_reg;
    logic signed [47:0]           pos_n_reg;
    logic                         pos_valid_reg;

    logic signed [31:0]           yaw_reg;
    logic signed [15:0]           spd_reg;
    logic [1:0]                   quad_reg;
    logic [47:0]                  dt_reg;
    logic                         integ_reg;
    logic signed [drt_pkg::XY_W-1:0] x_reg;
    logic signed [drt_pkg::XY_W-1:0] y_reg;
    logic signed [drt_pkg::Z_W-1:0]  z_reg;
    logic [ITER_W-1:0]            iter_reg;
    logic signed [47:0]           prod_reg;
    logic signed [63:0]           acc_reg;
    logic                         half_reg;
    logic                         axis_reg;

    logic                         out_valid_reg;
    drt_pkg::drt_result_t         res_reg;

    logic                         accept;
    logic signed [32:0]           yaw_base;
    logic signed [33:0]           yaw_sum;
    logic signed [31:0]           yaw_sat;
    logic                         moving;
    logic signed [15:0]           mul_a;
    logic signed [31:0]           mul_b;
    logic signed [47:0]           mul_p;
    logic signed [drt_pkg::XY_W-1:0] dx;
    logic signed [drt_pkg::XY_W-1:0] dy;
    logic signed [drt_pkg::Z_W-1:0]  atan_z;
    logic signed [drt_pkg::XY_W-1:0] x_rnd;
    logic signed [drt_pkg::XY_W-1:0] y_rnd;
    logic signed [20:0]           c_val;
    logic signed [20:0]           s_val;
    logic signed [20:0]           east_raw;
    logic signed [20:0]           north_raw;
    logic signed [63:0]           acc_term;
    logic signed [63:0]           acc_rnd;
    logic signed [47:0]           pos_sel;
    logic signed [52:0]           pos_sum;
    logic signed [47:0]           pos_sat;

    function automatic logic signed [15:0] sat_vel(input logic signed [20:0] v);
        if (v > 21'sd32767)
            return 16'sh7FFF;
        else if (v < -21'sd32768)
            return -16'sh8000;
        else
            return v[15:0];
    endfunction

    assign accept       = sample.valid && sample.ready;
    assign sample.ready = (state_reg == S_IDLE);
    assign result.valid = out_valid_reg;
    assign result.data  = res_reg;

    // yaw correction
    always_comb
    begin
        moving   = (sample.data.speed > $signed({1'b0, threshold_reg}));
        yaw_base = reverse_reg ? 33'(sample.data.yaw_rate_raw)
                               : -33'(sample.data.yaw_rate_raw);
        if (moving && sample.data.offset_moving_valid)
            yaw_sum = 34'(yaw_base) + 34'(sample.data.offset_moving);
        else
            yaw_sum = 34'(yaw_base) + 34'(sample.data.offset_stopped);
        if (yaw_sum[33:31] == 3'b000 || yaw_sum[33:31] == 3'b111)
            yaw_sat = yaw_sum[31:0];
        else if (yaw_sum[33])
            yaw_sat = 32'sh8000_0000;
        else
            yaw_sat = 32'sh7FFF_FFFF;
    end

    // shared multiplier
    always_comb
    begin
        if (state_reg == S_INIT)
        begin
            mul_a = spd_reg;
            mul_b = drt_pkg::KINV_Q30;
        end
        else
        begin
            mul_a = axis_reg ? vn_reg : ve_reg;
            mul_b = half_reg ? {{8{dt_reg[47]}}, dt_reg[47:24]} : {8'd0, dt_reg[23:0]};
        end
        mul_p = mul_a * mul_b;
    end

    // cordic step and output mapping
    always_comb
    begin
        dx     = y_reg >>> iter_reg;
        dy     = x_reg >>> iter_reg;
        atan_z = $signed({2'b00, drt_pkg::ATAN_TURN32[drt_pkg::ATAN_W'(iter_reg)]});
        x_rnd  = x_reg + ROUND_HALF;
        y_rnd  = y_reg + ROUND_HALF;
        c_val  = 21'($signed(x_rnd[drt_pkg::XY_W-1:30]));
        s_val  = 21'($signed(y_rnd[drt_pkg::XY_W-1:30]));
        case (quad_reg)
            2'd0:
            begin
                north_raw = c_val;
                east_raw  = s_val;
            end
            2'd1:
            begin
                north_raw = -s_val;
                east_raw  = c_val;
            end
            2'd2:
            begin
                north_raw = -c_val;
                east_raw  = -s_val;
            end
            default:
            begin
                north_raw = s_val;
                east_raw  = -c_val;
            end
        endcase
    end

    // position step
    always_comb
    begin
        acc_term = half_reg ? (64'(prod_reg) <<< 24) : 64'(prod_reg);
        acc_rnd  = acc_reg + 64'sd2048;
        pos_sel  = axis_reg ? pos_n_reg : pos_e_reg;
        pos_sum  = 53'(pos_sel) + 53'($signed(acc_rnd[63:12]));
        if (pos_sum[52:47] == 6'b000000 || pos_sum[52:47] == 6'b111111)
            pos_sat = pos_sum[47:0];
        else if (pos_sum[52])
            pos_sat = {1'b1, 47'd0};
        else
            pos_sat = {1'b0, {47{1'b1}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_WAIT;
            reverse_reg    <= 1'b0;
            threshold_reg  <= 15'd3;
            prev_stamp_reg <= '0;
            ve_reg         <= '0;
            vn_reg         <= '0;
            pos_e_reg      <= '0;
            pos_n_reg      <= '0;
            pos_valid_reg  <= 1'b0;
            yaw_reg        <= '0;
            spd_reg        <= '0;
            quad_reg       <= '0;
            dt_reg         <= '0;
            integ_reg      <= 1'b0;
            x_reg          <= '0;
            y_reg          <= '0;
            z_reg          <= '0;
            iter_reg       <= '0;
            prod_reg       <= '0;
            acc_reg        <= '0;
            half_reg       <= 1'b0;
            axis_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    drt_pkg::CFG_REVERSE_MOUNTING:     reverse_reg   <= cfg_data[0];
                    drt_pkg::CFG_STOP_SPEED_THRESHOLD: threshold_reg <= cfg_data;
                    default:                           reverse_reg   <= reverse_reg;
                endcase
            end

            if (out_valid_reg && result.ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        yaw_reg        <= yaw_sat;
                        spd_reg        <= sample.data.speed;
                        quad_reg       <= sample.data.heading[15:14];
                        dt_reg         <= sample.data.sample_stamp - prev_stamp_reg;
                        integ_reg      <= (sample.data.speed > 16'sd0)
                                          && (prev_stamp_reg != 48'd0);
                        prev_stamp_reg <= sample.data.sample_stamp;
                        z_reg          <= $signed({4'd0, sample.data.heading[13:0], 16'd0});
                        y_reg          <= '0;
                        iter_reg       <= '0;
                        if (phase_reg == PH_WAIT)
                        begin
                            if (sample.data.speed_valid && sample.data.heading_valid)
                                phase_reg <= PH_ONE;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            phase_reg <= PH_EST;
                            state_reg <= S_INIT;
                        end
                    end
                end
                S_INIT:
                begin
                    x_reg     <= drt_pkg::XY_W'(mul_p);
                    state_reg <= S_ROT;
                end
                S_ROT:
                begin
                    if (!z_reg[drt_pkg::Z_W-1])
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - atan_z;
                    end
                    else
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + atan_z;
                    end
                    iter_reg <= iter_reg + ITER_W'(1);
                    if (iter_reg == ITER_LAST)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    ve_reg   <= sat_vel(east_raw);
                    vn_reg   <= sat_vel(north_raw);
                    acc_reg  <= '0;
                    half_reg <= 1'b0;
                    axis_reg <= 1'b0;
                    state_reg <= integ_reg ? S_MUL : S_DONE;
                end
                S_MUL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    acc_reg <= acc_reg + acc_term;
                    if (!half_reg)
                    begin
                        half_reg  <= 1'b1;
                        state_reg <= S_MUL;
                    end
                    else
                        state_reg <= S_POS;
                end
                S_POS:
                begin
                    if (axis_reg)
                        pos_n_reg <= pos_sat;
                    else
                        pos_e_reg <= pos_sat;
                    acc_reg  <= '0;
                    half_reg <= 1'b0;
                    if (!axis_reg)
                    begin
                        axis_reg  <= 1'b1;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        pos_valid_reg <= 1'b1;
                        state_reg     <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        res_reg.yaw_rate_corrected <= yaw_reg;
                        res_reg.speed_out          <= spd_reg;
                        res_reg.velocity_east      <= ve_reg;
                        res_reg.velocity_north     <= vn_reg;
                        res_reg.position_east      <= pos_e_reg;
                        res_reg.position_north     <= pos_n_reg;
                        res_reg.position_valid     <= pos_valid_reg;
                        out_valid_reg              <= 1'b1;
                        state_reg                  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: sim/dead_reckoning_trajectory_unit_test.sv
`timescale 1ns / 100ps

module dead_reckoning_trajectory_unit_test;

    localparam int CORDIC_STEPS     = 16;
    localparam int STALL_LIMIT      = 4000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 40;
    localparam int PHASE_ITEMS      = 240;
    localparam int PHASE_COUNT      = 7;

    localparam longint START_GAIN = 64'sd652032874;
    localparam longint POS_MAX    = 64'sd140737488355327;
    localparam longint POS_MIN    = -64'sd140737488355328;
    localparam longint YAW_MAX    = 64'sd2147483647;
    localparam longint YAW_MIN    = -64'sd2147483648;

    localparam longint ANGLE_STEP [24] = '{
        536870912, 316933406, 167458907, 85004756,
        42667331,  21354465,  10679838,  5340245,
        2670163,   1335087,   667544,    333772,
        166886,    83443,     41722,     20861,
        10430,     5215,      2608,      1304,
        652,       326,       163,       81
    };

    localparam bit PHASE_REVERSE [PHASE_COUNT] = '{1, 0, 1, 0, 1, 0, 0};

    typedef enum logic [1:0] {
        TRACK_WAITING,
        TRACK_PRIMED,
        TRACK_ESTIMATING
    } track_phase_t;

    typedef struct {
        drt_pkg::drt_sample_t smp;
        bit                   typed;
        drt_pkg::drt_result_t want;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [14:0] cfg_data;

    drt_sample_if sample_ch();
    drt_result_if result_ch();

    dead_reckoning_trajectory_unit #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    // tracker copy: settings and state
    logic                reverse_setting;
    logic [14:0]         threshold_setting;
    track_phase_t        track_phase;
    logic [47:0]         stamp_seen;
    logic signed [15:0]  east_vel;
    logic signed [15:0]  north_vel;
    longint              east_pos;
    longint              north_pos;
    logic                pos_updated;

    drt_pkg::drt_result_t expected_results [$];
    drt_pkg::drt_result_t oldest_expected;
    directed_row_t        directed_rows [$];
    int                   error_count;
    int                   burst_left;
    bit                   long_hold_request;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void rotate_speed(input logic signed [15:0] spd,
                                         input logic [15:0] head,
                                         output logic signed [15:0] east,
                                         output logic signed [15:0] north);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint c;
        longint s;
        longint cs;
        longint sn;
        x = longint'(spd) * START_GAIN;
        y = 0;
        z = longint'(head[13:0]) * 65536;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ANGLE_STEP[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ANGLE_STEP[i];
            end
        end
        c = (x + (64'sd1 <<< 29)) >>> 30;
        s = (y + (64'sd1 <<< 29)) >>> 30;
        case (head[15:14])
            2'd0:
            begin
                cs = c;
                sn = s;
            end
            2'd1:
            begin
                cs = -s;
                sn = c;
            end
            2'd2:
            begin
                cs = -c;
                sn = -s;
            end
            default:
            begin
                cs = s;
                sn = -c;
            end
        endcase
        east  = 16'(clamp(sn, -32768, 32767));
        north = 16'(clamp(cs, -32768, 32767));
    endfunction

    function automatic longint advance_position(input longint pos, input longint vel,
                                                input longint dt);
        return clamp(pos + ((vel * dt + 2048) >>> 12), POS_MIN, POS_MAX);
    endfunction

    function automatic drt_pkg::drt_result_t predict_track(input drt_pkg::drt_sample_t s);
        drt_pkg::drt_result_t r;
        longint               base;
        longint               yaw;
        logic signed [47:0]   step;
        base = reverse_setting ? longint'($signed(s.yaw_rate_raw))
                               : -longint'($signed(s.yaw_rate_raw));
        if (longint'($signed(s.speed)) > longint'(threshold_setting) && s.offset_moving_valid)
            yaw = base + longint'($signed(s.offset_moving));
        else
            yaw = base + longint'($signed(s.offset_stopped));
        yaw = clamp(yaw, YAW_MIN, YAW_MAX);

        if (track_phase == TRACK_WAITING)
        begin
            if (s.speed_valid && s.heading_valid)
                track_phase = TRACK_PRIMED;
        end
        else
            track_phase = TRACK_ESTIMATING;

        if (track_phase == TRACK_ESTIMATING)
            rotate_speed(s.speed, s.heading, east_vel, north_vel);

        if (track_phase == TRACK_ESTIMATING && $signed(s.speed) > 0 && stamp_seen != 48'd0)
        begin
            step = s.sample_stamp - stamp_seen;
            east_pos    = advance_position(east_pos, east_vel, step);
            north_pos   = advance_position(north_pos, north_vel, step);
            pos_updated = 1'b1;
        end
        stamp_seen = s.sample_stamp;

        r.yaw_rate_corrected = 32'(yaw);
        r.speed_out          = s.speed;
        r.velocity_east      = east_vel;
        r.velocity_north     = north_vel;
        r.position_east      = 48'(east_pos);
        r.position_north     = 48'(north_pos);
        r.position_valid     = pos_updated;
        return r;
    endfunction

    function automatic drt_pkg::drt_sample_t make_sample(input logic signed [31:0] raw,
                                                         input logic [47:0] stamp,
                                                         input logic signed [15:0] spd,
                                                         input bit spd_ok,
                                                         input logic [15:0] head,
                                                         input bit head_ok,
                                                         input logic signed [23:0] off_mov,
                                                         input bit off_mov_ok,
                                                         input logic signed [23:0] off_stop);
        drt_pkg::drt_sample_t s;
        s.yaw_rate_raw        = raw;
        s.sample_stamp        = stamp;
        s.speed               = spd;
        s.speed_valid         = spd_ok;
        s.heading             = head;
        s.heading_valid       = head_ok;
        s.offset_moving       = off_mov;
        s.offset_moving_valid = off_mov_ok;
        s.offset_stopped      = off_stop;
        return s;
    endfunction

    function automatic drt_pkg::drt_result_t make_result(input logic signed [31:0] yaw,
                                                         input logic signed [15:0] spd,
                                                         input logic signed [15:0] ve,
                                                         input logic signed [15:0] vn,
                                                         input logic signed [47:0] pe,
                                                         input logic signed [47:0] pn,
                                                         input logic pv);
        drt_pkg::drt_result_t r;
        r.yaw_rate_corrected = yaw;
        r.speed_out          = spd;
        r.velocity_east      = ve;
        r.velocity_north     = vn;
        r.position_east      = pe;
        r.position_north     = pn;
        r.position_valid     = pv;
        return r;
    endfunction

    function automatic drt_pkg::drt_sample_t random_sample(input logic [47:0] prior);
        drt_pkg::drt_sample_t s;
        int                   pick;
        int                   near;
        case ($urandom_range(0, 7))
            0: s.yaw_rate_raw = 32'sh8000_0000;
            1: s.yaw_rate_raw = 32'sh7FFF_FFFF;
            default: s.yaw_rate_raw = $urandom;
        endcase

        pick = $urandom_range(0, 19);
        if (pick == 0)
            s.sample_stamp = 48'd0;
        else if (pick == 1)
            s.sample_stamp = {16'($urandom), 32'($urandom)};
        else if (pick == 2)
            s.sample_stamp = prior - 48'($urandom_range(1, 5000));
        else
            s.sample_stamp = prior + 48'($urandom_range(1, 20000));

        case ($urandom_range(0, 7))
            0: s.speed = 16'($urandom);
            1:
            begin
                near = int'(threshold_setting) + int'($urandom_range(0, 2)) - 1;
                if (near > 32767)
                    near = 32767;
                s.speed = 16'(near);
            end
            2: s.speed = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            3: s.speed = -16'($urandom_range(1, 500));
            default: s.speed = 16'($urandom_range(0, 2000));
        endcase

        s.speed_valid   = ($urandom_range(0, 3) != 0);
        s.heading       = 16'($urandom);
        s.heading_valid = ($urandom_range(0, 3) != 0);

        case ($urandom_range(0, 9))
            0: s.offset_moving = 24'sh80_0000;
            1: s.offset_moving = 24'sh7F_FFFF;
            default: s.offset_moving = 24'($urandom);
        endcase
        s.offset_moving_valid = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0: s.offset_stopped = 24'sh80_0000;
            1: s.offset_stopped = 24'sh7F_FFFF;
            default: s.offset_stopped = 24'($urandom);
        endcase
        return s;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic send_sample(input drt_pkg::drt_sample_t s, input bit typed,
                               input drt_pkg::drt_result_t typed_want);
        drt_pkg::drt_result_t predicted;
        int                   gap;
        sample_ch.data  <= s;
        sample_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        predicted = predict_track(s);
        expected_results.push_back(typed ? typed_want : predicted);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
            if (gap > 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic write_config(input logic reverse, input logic [14:0] threshold);
        cfg_we    <= 1'b1;
        cfg_index <= drt_pkg::CFG_REVERSE_MOUNTING;
        cfg_data  <= {14'd0, reverse};
        @(posedge clk);
        cfg_index <= drt_pkg::CFG_STOP_SPEED_THRESHOLD;
        cfg_data  <= threshold;
        @(posedge clk);
        cfg_we <= 1'b0;
        reverse_setting   = reverse;
        threshold_setting = threshold;
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // result side: pattern stalls plus one long hold
    initial
    begin
        logic [31:0] pattern;
        int          pos;
        int          hold_left;
        pattern   = '1;
        pos       = 0;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_request)
            begin
                long_hold_request = 1'b0;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= pattern[pos];
                pos++;
                if (pos == 32)
                begin
                    pos = 0;
                    case ($urandom_range(0, 3))
                        0: pattern = '1;
                        1: pattern = $urandom;
                        2: pattern = $urandom | $urandom;
                        default: pattern = $urandom & $urandom;
                    endcase
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected item", 0, 0);
            else
            begin
                oldest_expected = expected_results.pop_front();
                if (result_ch.data.yaw_rate_corrected !== oldest_expected.yaw_rate_corrected)
                    report_mismatch("yaw_rate_corrected",
                                    $signed(result_ch.data.yaw_rate_corrected),
                                    $signed(oldest_expected.yaw_rate_corrected));
                if (result_ch.data.speed_out !== oldest_expected.speed_out)
                    report_mismatch("speed_out", $signed(result_ch.data.speed_out),
                                    $signed(oldest_expected.speed_out));
                if (result_ch.data.velocity_east !== oldest_expected.velocity_east)
                    report_mismatch("velocity_east", $signed(result_ch.data.velocity_east),
                                    $signed(oldest_expected.velocity_east));
                if (result_ch.data.velocity_north !== oldest_expected.velocity_north)
                    report_mismatch("velocity_north", $signed(result_ch.data.velocity_north),
                                    $signed(oldest_expected.velocity_north));
                if (result_ch.data.position_east !== oldest_expected.position_east)
                    report_mismatch("position_east", $signed(result_ch.data.position_east),
                                    $signed(oldest_expected.position_east));
                if (result_ch.data.position_north !== oldest_expected.position_north)
                    report_mismatch("position_north", $signed(result_ch.data.position_north),
                                    $signed(oldest_expected.position_north));
                if (result_ch.data.position_valid !== oldest_expected.position_valid)
                    report_mismatch("position_valid", result_ch.data.position_valid,
                                    oldest_expected.position_valid);
            end
        end
    end

    // watchdog: cycles with no item moving on either side
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) ||
                (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[dead_reckoning_trajectory_unit] ERROR");
        $finish;
    end

    initial
    begin
        logic [47:0]          stamp_cursor;
        logic [14:0]          threshold;
        drt_pkg::drt_sample_t next_sample;

        sample_ch.valid <= 1'b0;
        sample_ch.data  <= '0;
        cfg_we          <= 1'b0;
        cfg_index       <= drt_pkg::CFG_REVERSE_MOUNTING;
        cfg_data        <= '0;
        rst_n           <= 1'b0;

        reverse_setting   = 1'b0;
        threshold_setting = 15'd3;
        track_phase       = TRACK_WAITING;
        stamp_seen        = '0;
        east_vel          = '0;
        north_vel         = '0;
        east_pos          = 0;
        north_pos         = 0;
        pos_updated       = 1'b0;
        error_count       = 0;
        burst_left        = 4;
        long_hold_request = 1'b0;

        // after reset, saturating yaw sums
        directed_rows.push_back('{make_sample(32'sd1000, 48'h100, 16'sd0, 0, 16'h0000, 0,
                                              24'sd0, 0, 24'sd5), 1'b1,
                                  make_result(-32'sd995, 16'sd0, 16'sd0, 16'sd0, '0, '0, 1'b0)});
        directed_rows.push_back('{make_sample(32'sh8000_0000, 48'h200, 16'sd0, 0, 16'h0000, 0,
                                              24'sd0, 0, 24'sh7F_FFFF), 1'b1,
                                  make_result(32'sh7FFF_FFFF, 16'sd0, 16'sd0, 16'sd0,
                                              '0, '0, 1'b0)});
        directed_rows.push_back('{make_sample(32'sh7FFF_FFFF, 48'h280, 16'sd0, 0, 16'h0000, 0,
                                              24'sd0, 0, 24'sh80_0000), 1'b1,
                                  make_result(32'sh8000_0000, 16'sd0, 16'sd0, 16'sd0,
                                              '0, '0, 1'b0)});
        // start-up, then quadrant corners at full speed
        directed_rows.push_back('{make_sample(32'sd12345, 48'h300, 16'sd100, 1, 16'h1234, 1,
                                              24'sh7F_FFFF, 1, -24'sd77), 1'b0, '0});
        directed_rows.push_back('{make_sample(-32'sd500, 48'h1000, 16'sh7FFF, 1, 16'h0000, 1,
                                              24'sd300, 1, -24'sd300), 1'b0, '0});
        directed_rows.push_back('{make_sample(32'sd7, 48'h2000, 16'sh7FFF, 1, 16'h4000, 1,
                                              24'sd1, 1, 24'sd2), 1'b0, '0});
        directed_rows.push_back('{make_sample(32'sd7, 48'h3000, 16'sh7FFF, 1, 16'h8000, 1,
                                              24'sd1, 1, 24'sd2), 1'b0, '0});
        directed_rows.push_back('{make_sample(32'sd7, 48'h4000, 16'sh7FFF, 1, 16'hC000, 1,
                                              24'sd1, 1, 24'sd2), 1'b0, '0});
        // negative speed, speed at threshold, moving offset not valid
        directed_rows.push_back('{make_sample(32'sd9, 48'h5000, 16'sh8000, 1, 16'hFFFF, 1,
                                              24'sd1, 1, 24'sd2), 1'b0, '0});
        directed_rows.push_back('{make_sample(32'sd9, 48'h6000, 16'sd3, 1, 16'h2000, 1,
                                              24'sd100, 1, 24'sd200), 1'b0, '0});
        directed_rows.push_back('{make_sample(32'sd9, 48'h7000, 16'sd4, 1, 16'h6000, 1,
                                              24'sd100, 0, 24'sd200), 1'b0, '0});
        // stamp backwards, zero stamp, blocked update after it
        directed_rows.push_back('{make_sample(-32'sd3, 48'h6800, 16'sd200, 1, 16'h9000, 1,
                                              24'sd5, 1, 24'sd6), 1'b0, '0});
        directed_rows.push_back('{make_sample(-32'sd3, 48'h0, 16'sd50, 1, 16'h1000, 1,
                                              24'sd5, 1, 24'sd6), 1'b0, '0});
        directed_rows.push_back('{make_sample(-32'sd3, 48'h8000, 16'sd50, 1, 16'h1000, 1,
                                              24'sd5, 1, 24'sd6), 1'b0, '0});
        // stamp extremes and position saturation both ways
        directed_rows.push_back('{make_sample(32'sd1, 48'hFFFF_FFFF_FFFF, 16'sh7FFF, 1, 16'h2000,
                                              1, 24'sd0, 1, 24'sd0), 1'b0, '0});
        directed_rows.push_back('{make_sample(32'sd1, 48'h7FFF_FFFF_0000, 16'sh7FFF, 1, 16'h2000,
                                              1, 24'sd0, 1, 24'sd0), 1'b0, '0});
        directed_rows.push_back('{make_sample(32'sd1, 48'hFFFF_FFFE_0000, 16'sh7FFF, 1, 16'hA000,
                                              1, 24'sd0, 1, 24'sd0), 1'b0, '0});
        // validity flags dropped while estimating
        directed_rows.push_back('{make_sample(32'sd0, 48'hFFFF_FFFF_0000, 16'sd10, 0, 16'h5555,
                                              0, 24'sh80_0000, 1, 24'sd9), 1'b0, '0});
        directed_rows.push_back('{make_sample(32'sh7FFF_FFFF, 48'h1, -16'sd1, 0, 16'hC001, 0,
                                              24'sd0, 0, 24'sh7F_FFFF), 1'b0, '0});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].want);
        sample_ch.valid <= 1'b0;
        stamp_cursor = directed_rows[directed_rows.size() - 1].smp.sample_stamp;

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            wait_drained();
            case (p)
                0: threshold = 15'd0;
                1: threshold = 15'h7FFF;
                2: threshold = 15'h7FFF;
                3: threshold = 15'd0;
                4: threshold = 15'($urandom_range(1, 400));
                5: threshold = 15'($urandom);
                default: threshold = 15'd3;
            endcase
            write_config(PHASE_REVERSE[p], threshold);
            if (p == 2)
                long_hold_request = 1'b1;
            repeat (PHASE_ITEMS)
            begin
                next_sample  = random_sample(stamp_cursor);
                stamp_cursor = next_sample.sample_stamp;
                send_sample(next_sample, 1'b0, '0);
            end
            sample_ch.valid <= 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("items missing", expected_results.size(), 0);
        if (error_count == 0)
            $display("[dead_reckoning_trajectory_unit] OK");
        else
            $display("[dead_reckoning_trajectory_unit] ERROR");
        $finish;
    end

endmodule
